// ===== design/gn3_pkg.sv =====
// Package for the 3D gradient noise block: permutation ROM and fixed-point widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gn3_pkg;

    localparam int IN_W        = 24;
    localparam int OUT_W       = 18;
    localparam int OUT_FRAC    = 16;
    localparam int FRAC_BITS_D = 16;
    localparam int TABLE_SIZE_D = 256;

    localparam logic [7:0] PERM [0:TABLE_SIZE_D-1] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
        8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
        8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
        8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
        8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
        8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
        8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
        8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
        8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,
        8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,
        8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,
        8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,
        8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
        8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
        8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
        8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
        8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
        8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
        8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

endpackage
`default_nettype wire

// ===== design/gn3_fade.sv =====
// Quintic fade 6t^5-15t^4+10t^3, three register stages (products per stage: 2, 1, 1).
// Depends on gn3_pkg for nothing but house style; width follows FRAC_BITS.
`timescale 1ns / 1ps
`default_nettype none
module gn3_fade #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [FRAC_BITS-1:0]   i_t,
    output logic signed [FRAC_BITS+1:0] o_fade
);
    localparam int W = FRAC_BITS + 6;
    localparam logic signed [W-1:0] TEN = W'(10) <<< FRAC_BITS;
    localparam logic signed [W-1:0] FIFTEEN = W'(15) <<< FRAC_BITS;
    localparam logic signed [2*W-1:0] HALF = (2*W)'(1) <<< (FRAC_BITS-1);

    logic signed [W-1:0] t0, a0, b1, t2, t3, r_t1, r_b, r_t2, r_b2, r_t3;
    logic signed [2*W-1:0] p_b, p_t2, p_t3, p_f;

    assign t0 = W'(i_t);
    // 6t as 4t + 2t
    assign a0 = (t0 <<< 2) + (t0 <<< 1) - FIFTEEN;
    assign p_b  = t0 * a0 + HALF;
    assign p_t2 = t0 * t0 + HALF;
    assign p_t3 = r_t2 * r_t1 + HALF;
    assign p_f  = r_t3 * r_b2 + HALF;
    assign b1 = W'(p_b >>> FRAC_BITS) + TEN;
    assign t2 = W'(p_t2 >>> FRAC_BITS);
    assign t3 = W'(p_t3 >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= t0;
            r_b    <= b1;
            r_t2   <= t2;
            r_b2   <= r_b;
            r_t3   <= t3;
            o_fade <= (FRAC_BITS+2)'(p_f >>> FRAC_BITS);
        end
    end
endmodule
`default_nettype wire

// ===== design/gn3_hash.sv =====
// Lattice hashing: three ROM levels give the eight corner hash codes (4 bits each).
// Depends on gn3_pkg (PERM). Three register stages.
`timescale 1ns / 1ps
`default_nettype none
module gn3_hash (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [7:0] i_cx,
    input  wire logic [7:0] i_cy,
    input  wire logic [7:0] i_cz,
    output logic [3:0]      o_h [0:7]
);
    logic [7:0] r_ha, r_hb, r_cz1;
    logic [7:0] r_haa, r_hab, r_hba, r_hbb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ha  <= gn3_pkg::PERM[i_cx] + i_cy;
            r_hb  <= gn3_pkg::PERM[i_cx + 8'd1] + i_cy;
            r_cz1 <= i_cz;
            r_haa <= gn3_pkg::PERM[r_ha] + r_cz1;
            r_hab <= gn3_pkg::PERM[r_ha + 8'd1] + r_cz1;
            r_hba <= gn3_pkg::PERM[r_hb] + r_cz1;
            r_hbb <= gn3_pkg::PERM[r_hb + 8'd1] + r_cz1;
            // corner order: bit0 = x, bit1 = y, bit2 = z
            o_h[0] <= gn3_pkg::PERM[r_haa][3:0];
            o_h[1] <= gn3_pkg::PERM[r_hba][3:0];
            o_h[2] <= gn3_pkg::PERM[r_hab][3:0];
            o_h[3] <= gn3_pkg::PERM[r_hbb][3:0];
            o_h[4] <= gn3_pkg::PERM[r_haa + 8'd1][3:0];
            o_h[5] <= gn3_pkg::PERM[r_hba + 8'd1][3:0];
            o_h[6] <= gn3_pkg::PERM[r_hab + 8'd1][3:0];
            o_h[7] <= gn3_pkg::PERM[r_hbb + 8'd1][3:0];
        end
    end
endmodule
`default_nettype wire

// ===== design/gn3_lerp.sv =====
// One registered linear interpolation a + round(t*(b-a)).
// Width follows FRAC_BITS; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gn3_lerp #(
    parameter int FRAC_BITS = 16,
    parameter int W = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic signed [FRAC_BITS+1:0] i_t,
    input  wire logic signed [W-1:0]    i_a,
    input  wire logic signed [W-1:0]    i_b,
    output logic signed [W-1:0]         o_y
);
    localparam int PW = W + FRAC_BITS + 4;
    logic signed [W:0]    d;
    logic signed [PW-1:0] p;
    assign d = (W+1)'(i_b) - (W+1)'(i_a);
    assign p = PW'(i_t) * PW'(d) + (PW'(1) <<< (FRAC_BITS-1));
    always_ff @(posedge i_clk) begin
        if (i_en) o_y <= i_a + W'(p >>> FRAC_BITS);
    end
endmodule
`default_nettype wire

// ===== design/gradient_noise_3d.sv =====
// 3D improved gradient noise, fully pipelined.
// Throughput: one word per cycle; the whole pipeline advances whenever the output word
// is not stalled. Synchronous active-low reset clears the valid bits only.
// Stages: split/hash x3 with fade x3, gradients, then lerp x3 tree (shared advance).
// Depends on gn3_pkg, gn3_fade, gn3_hash, gn3_lerp.
`timescale 1ns / 1ps
`default_nettype none
module gradient_noise_3d #(
    parameter int FRAC_BITS  = gn3_pkg::FRAC_BITS_D
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic signed [gn3_pkg::IN_W-1:0] i_coord_x,
    input  wire logic signed [gn3_pkg::IN_W-1:0] i_coord_y,
    input  wire logic signed [gn3_pkg::IN_W-1:0] i_coord_z,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [gn3_pkg::OUT_W-1:0] o_noise_value
);
    localparam int DEPTH = 7;
    localparam int GW = FRAC_BITS + 3;   // gradient / lerp value width
    localparam int IB = gn3_pkg::IN_W - FRAC_BITS;
    localparam logic signed [GW-1:0] ONE = GW'(1) <<< FRAC_BITS;

    logic [DEPTH-1:0] r_vld;
    logic             en;
    // pipeline advances unless the output holds a word that is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en)  r_vld <= {r_vld[DEPTH-2:0], i_valid};
    end

    // lattice cell: low 8 bits of floor
    logic [7:0] cx, cy, cz;
    logic [FRAC_BITS-1:0] fx, fy, fz;
    always_comb begin
        cx = 8'hff; cy = 8'hff; cz = 8'hff;
        if (IB > 0) begin
            cx = 8'(i_coord_x >>> FRAC_BITS);
            cy = 8'(i_coord_y >>> FRAC_BITS);
            cz = 8'(i_coord_z >>> FRAC_BITS);
        end else begin
            if (!i_coord_x[gn3_pkg::IN_W-1]) cx = 8'd0;
            if (!i_coord_y[gn3_pkg::IN_W-1]) cy = 8'd0;
            if (!i_coord_z[gn3_pkg::IN_W-1]) cz = 8'd0;
        end
    end
    assign fx = i_coord_x[FRAC_BITS-1:0];
    assign fy = i_coord_y[FRAC_BITS-1:0];
    assign fz = i_coord_z[FRAC_BITS-1:0];

    logic [3:0] h [0:7];
    gn3_hash u_hash (.i_clk, .i_en(en), .i_cx(cx), .i_cy(cy), .i_cz(cz), .o_h(h));

    logic signed [FRAC_BITS+1:0] u, v, w;
    gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fu (.i_clk, .i_en(en), .i_t(fx), .o_fade(u));
    gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fv (.i_clk, .i_en(en), .i_t(fy), .o_fade(v));
    gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fw (.i_clk, .i_en(en), .i_t(fz), .o_fade(w));

    // fraction delay to line up with hash output (3 stages)
    logic [FRAC_BITS-1:0] r_fx [0:2], r_fy [0:2], r_fz [0:2];
    logic signed [FRAC_BITS+1:0] r_v [0:1], r_w [0:2];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx[0] <= fx; r_fx[1] <= r_fx[0]; r_fx[2] <= r_fx[1];
            r_fy[0] <= fy; r_fy[1] <= r_fy[0]; r_fy[2] <= r_fy[1];
            r_fz[0] <= fz; r_fz[1] <= r_fz[0]; r_fz[2] <= r_fz[1];
            r_v[0] <= v; r_v[1] <= r_v[0];
            r_w[0] <= w; r_w[1] <= r_w[0]; r_w[2] <= r_w[1];
        end
    end

    function automatic logic signed [GW-1:0] grad(input logic [3:0] hh,
            input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
            input logic signed [GW-1:0] z);
        logic signed [GW-1:0] g0, g1;
        g0 = (hh < 4'd8) ? x : y;
        g1 = (hh < 4'd4) ? y : ((hh == 4'd12 || hh == 4'd14) ? x : z);
        return (hh[0] ? -g0 : g0) + (hh[1] ? -g1 : g1);
    endfunction

    logic signed [GW-1:0] r_g [0:7];
    logic signed [FRAC_BITS+1:0] r_u;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u <= u;
            for (int k = 0; k < 8; k++) begin
                r_g[k] <= grad(h[k],
                    GW'(r_fx[2]) - (k[0] ? ONE : GW'(0)),
                    GW'(r_fy[2]) - (k[1] ? ONE : GW'(0)),
                    GW'(r_fz[2]) - (k[2] ? ONE : GW'(0)));
            end
        end
    end

    logic signed [GW-1:0] l1 [0:3], l2 [0:1], n;
    for (genvar k = 0; k < 4; k++) begin : g_l1
        gn3_lerp #(.FRAC_BITS(FRAC_BITS), .W(GW)) u_l (.i_clk, .i_en(en), .i_t(r_u),
            .i_a(r_g[2*k]), .i_b(r_g[2*k+1]), .o_y(l1[k]));
    end
    gn3_lerp #(.FRAC_BITS(FRAC_BITS), .W(GW)) u_l20 (.i_clk, .i_en(en), .i_t(r_v[1]),
        .i_a(l1[0]), .i_b(l1[1]), .o_y(l2[0]));
    gn3_lerp #(.FRAC_BITS(FRAC_BITS), .W(GW)) u_l21 (.i_clk, .i_en(en), .i_t(r_v[1]),
        .i_a(l1[2]), .i_b(l1[3]), .o_y(l2[1]));
    // w is used by the lerp level after the one that uses v
    gn3_lerp #(.FRAC_BITS(FRAC_BITS), .W(GW)) u_l3 (.i_clk, .i_en(en), .i_t(r_w[2]),
        .i_a(l2[0]), .i_b(l2[1]), .o_y(n));

    // scale to Q1.16 and saturate
    localparam int SW = GW + 18;
    logic signed [SW-1:0] ns;
    always_comb begin
        if (FRAC_BITS > gn3_pkg::OUT_FRAC)
            ns = (SW'(n) + (SW'(1) <<< (FRAC_BITS - gn3_pkg::OUT_FRAC - 1)))
                 >>> (FRAC_BITS - gn3_pkg::OUT_FRAC);
        else
            ns = SW'(n) <<< (gn3_pkg::OUT_FRAC - FRAC_BITS);
    end
    always_comb begin
        if (ns > SW'(65536))       o_noise_value = 18'sd65536;
        else if (ns < -SW'(65536)) o_noise_value = -18'sd65536;
        else                       o_noise_value = ns[gn3_pkg::OUT_W-1:0];
    end

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall without a held word");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_noise_value)))
        else $error("stalled word changed");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_noise_value <= 18'sd65536 && o_noise_value >= -18'sd65536))
        else $error("saturation broken");
`endif
endmodule
`default_nettype wire
